### rtl/core/ntfm_pkg.sv
`default_nettype none
package ntfm_pkg;

  // channel and lane shape
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned OFF_W     = 20;
  localparam int unsigned DIR_W     = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TOF_W     = TIME_W + 1;

  // flight distance: 40 bit sum of squares, 20 bit root
  localparam int unsigned D2_W      = 2 * OFF_W;
  localparam int unsigned D_W       = OFF_W;
  localparam int unsigned DSQ_STEPS = D_W;
  localparam int unsigned FRONT_LAT = 3 + DSQ_STEPS;

  // beta and gamma arithmetic
  localparam int unsigned DD_W     = 47;
  localparam int unsigned LEN_W    = 61;
  localparam int unsigned BQ_W     = 32;
  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned NUM_W    = 52;
  localparam int unsigned PQ_W     = 36;
  localparam int unsigned LANE_LAT = 3 + BQ_W + SQ_STEPS + PQ_W;

  localparam logic [26:0]      DIST_SCALE = 27'd100000000;
  localparam logic [28:0]      LIGHT_NUM  = 29'd299792458;
  localparam logic [19:0]      MASS_KEV   = 20'd939570;
  localparam logic [NUM_W-1:0] E_NUM      = {MASS_KEV, 32'd0};

  localparam logic signed [52:0] SAT_HI = 53'sd2147483647;
  localparam logic signed [52:0] SAT_LO = -53'sd2147483648;

  // result index codes
  typedef logic [1:0] which_t;
  localparam which_t WHICH_MAIN = 2'd0;
  localparam which_t WHICH_ONE  = 2'd1;
  localparam which_t WHICH_TWO  = 2'd2;

  typedef logic signed [TOF_W-1:0] tof_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
  } dir_vec_t;

  typedef struct packed {
    logic signed [OFF_W-1:0]  x;
    logic signed [OFF_W-1:0]  y;
    logic signed [OFF_W-1:0]  z;
    dir_vec_t                 dir;
    logic signed [TIME_W-1:0] hit;
    logic signed [TIME_W-1:0] one;
    logic signed [TIME_W-1:0] two;
    logic signed [TIME_W-1:0] tgt;
    logic                     has_one;
    logic                     has_two;
  } in_pay_t;

  typedef struct packed {
    tof_t [NUM_LANES-1:0] tof;
    dir_vec_t             dir;
  } front_carry_t;

  typedef struct packed {
    logic [D_W-1:0]       d;
    tof_t [NUM_LANES-1:0] tof;
    dir_vec_t             dir;
  } front_t;

  typedef struct packed {
    logic ok;
    tof_t tof;
  } lane_carry_t;

  typedef struct packed {
    logic            ok;
    logic [PQ_W-1:0] p;
    logic [31:0]     e;
    tof_t            tof;
  } lane_res_t;

  // root state of the distance square root
  typedef struct packed {
    logic [22:0]    rem;
    logic [D_W-1:0] root;
  } dsq_t;

  // root state of the gamma square root
  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
  } bsq_t;

  localparam dsq_t DSQ_ZERO = '0;
  localparam bsq_t BSQ_ZERO = '0;

  // one radix-4 digit of the distance root
  function automatic dsq_t dsq_step(dsq_t cur, logic [1:0] pair);
    logic [22:0] acc;
    logic [22:0] trial;
    dsq_t        nxt;
    acc   = {cur.rem[20:0], pair};
    trial = {1'b0, cur.root, 2'b01};
    if (acc >= trial) begin
      nxt.rem  = acc - trial;
      nxt.root = {cur.root[D_W-2:0], 1'b1};
    end else begin
      nxt.rem  = acc;
      nxt.root = {cur.root[D_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // one radix-4 digit of the gamma root
  function automatic bsq_t bsq_step(bsq_t cur, logic [1:0] pair);
    logic [34:0] acc;
    logic [34:0] trial;
    bsq_t        nxt;
    acc   = {cur.rem[32:0], pair};
    trial = {1'b0, cur.root, 2'b01};
    if (acc >= trial) begin
      nxt.rem  = acc - trial;
      nxt.root = {cur.root[30:0], 1'b1};
    end else begin
      nxt.rem  = acc;
      nxt.root = {cur.root[30:0], 1'b0};
    end
    return nxt;
  endfunction

  // one quotient bit of beta, returns {bit, remainder}
  function automatic logic [LEN_W:0] bdiv_step(logic [LEN_W-1:0] r, logic [LEN_W-1:0] len);
    logic [LEN_W:0] acc;
    logic [LEN_W:0] res;
    acc = {r, 1'b0};
    if (acc >= {1'b0, len}) begin
      res = {1'b1, LEN_W'(acc - {1'b0, len})};
    end else begin
      res = {1'b0, acc[LEN_W-1:0]};
    end
    return res;
  endfunction

  // one quotient bit of p or e, returns {bit, remainder}
  function automatic logic [32:0] pdiv_step(logic [31:0] rem, logic [31:0] s, logic nb);
    logic [32:0] acc;
    logic [32:0] res;
    acc = {rem, nb};
    if (acc >= {1'b0, s}) begin
      res = {1'b1, 32'(acc - {1'b0, s})};
    end else begin
      res = {1'b0, acc[31:0]};
    end
    return res;
  endfunction

  // clamp to the signed 32 bit range
  function automatic logic [31:0] sat32(logic signed [52:0] v);
    logic [31:0] res;
    if (v > SAT_HI) begin
      res = 32'h7fff_ffff;
    end else if (v < SAT_LO) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/core/ntfm_in_if.sv
`default_nettype none
interface ntfm_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] offset_x;
  logic signed [19:0] offset_y;
  logic signed [19:0] offset_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic signed [31:0] hit_time;
  logic signed [31:0] extra_time_one;
  logic signed [31:0] extra_time_two;
  logic signed [31:0] target_time;
  logic               has_extra_one;
  logic               has_extra_two;

  modport source(
    output valid, offset_x, offset_y, offset_z, dir_x, dir_y, dir_z, hit_time,
           extra_time_one, extra_time_two, target_time, has_extra_one, has_extra_two,
    input  ready
  );
  modport sink(
    input  valid, offset_x, offset_y, offset_z, dir_x, dir_y, dir_z, hit_time,
           extra_time_one, extra_time_two, target_time, has_extra_one, has_extra_two,
    output ready
  );
endinterface
`default_nettype wire

### rtl/core/ntfm_out_if.sv
`default_nettype none
interface ntfm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         which;
  logic               valid_res;
  logic signed [31:0] mom_x;
  logic signed [31:0] mom_y;
  logic signed [31:0] mom_z;
  logic [31:0]        energy;
  logic signed [31:0] flight_time;
  logic               last;

  modport source(
    output valid, which, valid_res, mom_x, mom_y, mom_z, energy, flight_time, last,
    input  ready
  );
  modport sink(
    input  valid, which, valid_res, mom_x, mom_y, mom_z, energy, flight_time, last,
    output ready
  );
endinterface
`default_nettype wire

### rtl/core/ntfm_front.sv
`default_nettype none
module ntfm_front
  import ntfm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  ntfm_in_if.sink   in_i,
  output logic      valid_o,
  output front_t    front_o
);

  logic         v_q [FRONT_LAT];
  in_pay_t      p0_q;
  logic [38:0]  sq_q [3];
  front_carry_t c1_q;
  logic [D2_W-1:0] d2_q;
  front_carry_t c2_q;
  dsq_t         sr_q  [DSQ_STEPS];
  logic [D2_W-1:0] rad_q [DSQ_STEPS];
  front_carry_t c_q   [DSQ_STEPS];

  logic signed [D2_W-1:0] sq_x, sq_y, sq_z;
  tof_t t_hit, t_one, t_two;

  assign in_i.ready = en_i;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRONT_LAT; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= in_i.valid;
      for (int i = 1; i < FRONT_LAT; i++) v_q[i] <= v_q[i-1];
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q.x       <= in_i.offset_x;
      p0_q.y       <= in_i.offset_y;
      p0_q.z       <= in_i.offset_z;
      p0_q.dir.x   <= in_i.dir_x;
      p0_q.dir.y   <= in_i.dir_y;
      p0_q.dir.z   <= in_i.dir_z;
      p0_q.hit     <= in_i.hit_time;
      p0_q.one     <= in_i.extra_time_one;
      p0_q.two     <= in_i.extra_time_two;
      p0_q.tgt     <= in_i.target_time;
      p0_q.has_one <= in_i.has_extra_one;
      p0_q.has_two <= in_i.has_extra_two;
    end
  end

  // squares and flight times
  assign sq_x  = p0_q.x * p0_q.x;
  assign sq_y  = p0_q.y * p0_q.y;
  assign sq_z  = p0_q.z * p0_q.z;
  assign t_hit = {p0_q.hit[TIME_W-1], p0_q.hit} - {p0_q.tgt[TIME_W-1], p0_q.tgt};
  assign t_one = {p0_q.one[TIME_W-1], p0_q.one} - {p0_q.tgt[TIME_W-1], p0_q.tgt};
  assign t_two = {p0_q.two[TIME_W-1], p0_q.two} - {p0_q.tgt[TIME_W-1], p0_q.tgt};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0]    <= sq_x[38:0];
      sq_q[1]    <= sq_y[38:0];
      sq_q[2]    <= sq_z[38:0];
      c1_q.tof[0] <= t_hit;
      c1_q.tof[1] <= p0_q.has_one ? t_one : '0;
      c1_q.tof[2] <= p0_q.has_two ? t_two : '0;
      c1_q.dir   <= p0_q.dir;
    end
  end

  // squared distance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_q <= D2_W'(sq_q[0]) + D2_W'(sq_q[1]) + D2_W'(sq_q[2]);
      c2_q <= c1_q;
    end
  end

  // distance root, one digit per stage
  for (genvar g = 0; g < DSQ_STEPS; g++) begin : g_dsq
    if (g == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sr_q[0]  <= dsq_step(DSQ_ZERO, d2_q[D2_W-1:D2_W-2]);
          rad_q[0] <= {d2_q[D2_W-3:0], 2'b00};
          c_q[0]   <= c2_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sr_q[g]  <= dsq_step(sr_q[g-1], rad_q[g-1][D2_W-1:D2_W-2]);
          rad_q[g] <= {rad_q[g-1][D2_W-3:0], 2'b00};
          c_q[g]   <= c_q[g-1];
        end
      end
    end
  end

  assign valid_o     = v_q[FRONT_LAT-1];
  assign front_o.d   = sr_q[DSQ_STEPS-1].root;
  assign front_o.tof = c_q[DSQ_STEPS-1].tof;
  assign front_o.dir = c_q[DSQ_STEPS-1].dir;

endmodule
`default_nettype wire

### rtl/core/ntfm_lane.sv
`default_nettype none
module ntfm_lane
  import ntfm_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [D_W-1:0] d_i,
  input  wire tof_t           tof_i,
  output lane_res_t           res_o
);

  // scaled distance and light path
  logic [DD_W-1:0]  dd_q;
  logic [LEN_W-1:0] len_q;
  lane_carry_t      ca_q;

  // beta division
  logic [LEN_W:0]   bd_step [BQ_W];
  logic [LEN_W-1:0] bd_r_q   [BQ_W];
  logic [LEN_W-1:0] bd_len_q [BQ_W];
  logic [BQ_W-1:0]  bd_qt_q  [BQ_W];
  lane_carry_t      bd_c_q   [BQ_W];

  // beta squared
  logic [63:0]      bb;
  logic [31:0]      b2_q;
  logic [BQ_W-1:0]  bm_bq_q;
  lane_carry_t      bm_c_q;

  // gamma root
  logic [31:0]      qv;
  bsq_t             sq_q     [SQ_STEPS];
  logic [31:0]      sq_rad_q [SQ_STEPS];
  logic [BQ_W-1:0]  sq_bq_q  [SQ_STEPS];
  lane_carry_t      sq_c_q   [SQ_STEPS];

  // numerators
  logic [NUM_W-1:0] np_q;
  logic [31:0]      s_q;
  lane_carry_t      nm_c_q;

  // p and e division
  logic [32:0]      pd_pstep [PQ_W];
  logic [32:0]      pd_estep [PQ_W];
  logic [31:0]      pd_pr_q  [PQ_W];
  logic [31:0]      pd_er_q  [PQ_W];
  logic [PQ_W-1:0]  pd_pq_q  [PQ_W];
  logic [PQ_W-1:0]  pd_eq_q  [PQ_W];
  logic [NUM_W-1:0] pd_np_q  [PQ_W];
  logic [31:0]      pd_s_q   [PQ_W];
  lane_carry_t      pd_c_q   [PQ_W];

  // products of distance and time with their scale constants
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dd_q   <= DD_W'(d_i * DIST_SCALE);
      len_q  <= LEN_W'(tof_i[TIME_W-1:0] * LIGHT_NUM);
      ca_q.ok  <= (d_i != '0) && !tof_i[TOF_W-1] && (tof_i != '0);
      ca_q.tof <= tof_i;
    end
  end

  // beta as a Q0.32 fraction, one quotient bit per stage
  for (genvar g = 0; g < BQ_W; g++) begin : g_bd
    if (g == 0) begin : g_first
      assign bd_step[0] = bdiv_step(LEN_W'(dd_q), len_q);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          bd_r_q[0]     <= bd_step[0][LEN_W-1:0];
          bd_len_q[0]   <= len_q;
          bd_qt_q[0]    <= {{(BQ_W-1){1'b0}}, bd_step[0][LEN_W]};
          bd_c_q[0].ok  <= ca_q.ok && (LEN_W'(dd_q) < len_q);
          bd_c_q[0].tof <= ca_q.tof;
        end
      end
    end else begin : g_next
      assign bd_step[g] = bdiv_step(bd_r_q[g-1], bd_len_q[g-1]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          bd_r_q[g]   <= bd_step[g][LEN_W-1:0];
          bd_len_q[g] <= bd_len_q[g-1];
          bd_qt_q[g]  <= {bd_qt_q[g-1][BQ_W-2:0], bd_step[g][LEN_W]};
          bd_c_q[g]   <= bd_c_q[g-1];
        end
      end
    end
  end

  // beta squared, upper half
  assign bb = bd_qt_q[BQ_W-1] * bd_qt_q[BQ_W-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b2_q    <= bb[63:32];
      bm_bq_q <= bd_qt_q[BQ_W-1];
      bm_c_q  <= bd_c_q[BQ_W-1];
    end
  end

  // one minus beta squared, kept below one
  assign qv = (b2_q == '0) ? '1 : 32'(33'h1_0000_0000 - {1'b0, b2_q});

  // square root of q scaled by 2^32, one digit per stage
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    if (g == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sq_q[0]     <= bsq_step(BSQ_ZERO, qv[31:30]);
          sq_rad_q[0] <= {qv[29:0], 2'b00};
          sq_bq_q[0]  <= bm_bq_q;
          sq_c_q[0]   <= bm_c_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sq_q[g]     <= bsq_step(sq_q[g-1], sq_rad_q[g-1][31:30]);
          sq_rad_q[g] <= {sq_rad_q[g-1][29:0], 2'b00};
          sq_bq_q[g]  <= sq_bq_q[g-1];
          sq_c_q[g]   <= sq_c_q[g-1];
        end
      end
    end
  end

  // momentum numerator and divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      np_q   <= NUM_W'(MASS_KEV * sq_bq_q[SQ_STEPS-1]);
      s_q    <= (sq_q[SQ_STEPS-1].root == '0) ? 32'd1 : sq_q[SQ_STEPS-1].root;
      nm_c_q <= sq_c_q[SQ_STEPS-1];
    end
  end

  // p and e quotients, one bit of each per stage
  for (genvar g = 0; g < PQ_W; g++) begin : g_pd
    if (g == 0) begin : g_first
      assign pd_pstep[0] = pdiv_step(32'(np_q[NUM_W-1:PQ_W]), s_q, np_q[PQ_W-1]);
      assign pd_estep[0] = pdiv_step(32'(E_NUM[NUM_W-1:PQ_W]), s_q, E_NUM[PQ_W-1]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pd_pr_q[0] <= pd_pstep[0][31:0];
          pd_er_q[0] <= pd_estep[0][31:0];
          pd_pq_q[0] <= {{(PQ_W-1){1'b0}}, pd_pstep[0][32]};
          pd_eq_q[0] <= {{(PQ_W-1){1'b0}}, pd_estep[0][32]};
          pd_np_q[0] <= np_q;
          pd_s_q[0]  <= s_q;
          pd_c_q[0]  <= nm_c_q;
        end
      end
    end else begin : g_next
      assign pd_pstep[g] = pdiv_step(pd_pr_q[g-1], pd_s_q[g-1], pd_np_q[g-1][PQ_W-1-g]);
      assign pd_estep[g] = pdiv_step(pd_er_q[g-1], pd_s_q[g-1], E_NUM[PQ_W-1-g]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pd_pr_q[g] <= pd_pstep[g][31:0];
          pd_er_q[g] <= pd_estep[g][31:0];
          pd_pq_q[g] <= {pd_pq_q[g-1][PQ_W-2:0], pd_pstep[g][32]};
          pd_eq_q[g] <= {pd_eq_q[g-1][PQ_W-2:0], pd_estep[g][32]};
          pd_np_q[g] <= pd_np_q[g-1];
          pd_s_q[g]  <= pd_s_q[g-1];
          pd_c_q[g]  <= pd_c_q[g-1];
        end
      end
    end
  end

  assign res_o.ok  = pd_c_q[PQ_W-1].ok;
  assign res_o.p   = pd_pq_q[PQ_W-1];
  assign res_o.e   = (pd_eq_q[PQ_W-1][PQ_W-1:32] != '0) ? '1 : pd_eq_q[PQ_W-1][31:0];
  assign res_o.tof = pd_c_q[PQ_W-1].tof;

endmodule
`default_nettype wire

### rtl/core/ntfm_merge.sv
`default_nettype none
module ntfm_merge
  import ntfm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire dir_vec_t  dir_i,
  input  wire lane_res_t res_i [NUM_LANES],
  output logic           en_o,
  ntfm_out_if.source     out_o
);

  logic      dl_v_q   [LANE_LAT];
  dir_vec_t  dl_dir_q [LANE_LAT];
  lane_res_t buf_q    [NUM_LANES];
  dir_vec_t  bdir_q;
  logic      buf_v_q;
  which_t    cnt_q;

  logic        out_v_q;
  which_t      which_q;
  logic        vres_q;
  logic [31:0] momx_q, momy_q, momz_q, energy_q, ft_q;
  logic        last_q;

  logic      out_load, ser_load, good;
  lane_res_t cur;

  // scale p by a Q1.15 direction, truncating toward zero
  function automatic logic [31:0] mom_scale(logic [PQ_W-1:0] p, logic signed [DIR_W-1:0] dir);
    logic signed [52:0] prod;
    logic signed [52:0] adj;
    prod = $signed({1'b0, p}) * dir;
    adj  = prod[52] ? prod + 53'sd32767 : prod;
    return sat32(adj >>> 15);
  endfunction

  // handshake and stall control
  assign out_load = !out_v_q || out_o.ready;
  assign ser_load = !buf_v_q || (out_load && (cnt_q == WHICH_TWO));
  assign en_o     = !dl_v_q[LANE_LAT-1] || ser_load;

  // valid and direction follow the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) dl_v_q[i] <= 1'b0;
    end else if (en_o) begin
      dl_v_q[0] <= valid_i;
      for (int i = 1; i < LANE_LAT; i++) dl_v_q[i] <= dl_v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      dl_dir_q[0] <= dir_i;
      for (int i = 1; i < LANE_LAT; i++) dl_dir_q[i] <= dl_dir_q[i-1];
    end
  end

  // result selection
  always_comb begin
    case (cnt_q)
      WHICH_MAIN: cur = buf_q[0];
      WHICH_ONE:  cur = buf_q[1];
      WHICH_TWO:  cur = buf_q[2];
      default:    cur = buf_q[0];
    endcase
  end

  assign good = cur.ok && ((cnt_q == WHICH_MAIN) || buf_q[0].ok);

  // hit buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_v_q <= 1'b0;
      cnt_q   <= WHICH_MAIN;
      out_v_q <= 1'b0;
    end else begin
      if (ser_load) begin
        buf_v_q <= dl_v_q[LANE_LAT-1];
        cnt_q   <= WHICH_MAIN;
      end else if (out_load && buf_v_q) begin
        cnt_q <= which_t'(cnt_q + 2'd1);
      end
      if (out_load) out_v_q <= buf_v_q;
    end
  end

  // hit buffer and output payload
  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      for (int i = 0; i < NUM_LANES; i++) buf_q[i] <= res_i[i];
      bdir_q <= dl_dir_q[LANE_LAT-1];
    end
    if (out_load) begin
      which_q  <= cnt_q;
      vres_q   <= good;
      momx_q   <= good ? mom_scale(cur.p, bdir_q.x) : '1;
      momy_q   <= good ? mom_scale(cur.p, bdir_q.y) : '1;
      momz_q   <= good ? mom_scale(cur.p, bdir_q.z) : '1;
      energy_q <= good ? cur.e : '1;
      ft_q     <= sat32(53'(cur.tof));
      last_q   <= (cnt_q == WHICH_TWO);
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.which       = which_q;
  assign out_o.valid_res   = vres_q;
  assign out_o.mom_x       = momx_q;
  assign out_o.mom_y       = momy_q;
  assign out_o.mom_z       = momz_q;
  assign out_o.energy      = energy_q;
  assign out_o.flight_time = ft_q;
  assign out_o.last        = last_q;

endmodule
`default_nettype wire

### rtl/core/neutron_tof_four_momentum.sv
`default_nettype none
// channel  dir  handshake        payload
// in_i     in   valid / ready    offsets, direction, four times, two presence flags
// out_o    out  valid / ready    which, valid_res, mom_x/y/z, energy, flight_time, last
//
// The path runs through 23 front stages (input register, squares, sum, 20 root digits) and
// 103 lane stages, then the hit buffer and the output register.
// Each hit yields three results, sent one after the other on the one output port; new
// hits enter while older ones are still in the pipe.
// Reset clears only the valid bits and the buffer counter.
// When the buffer cannot take the hit at the pipe's end, the whole pipe holds.
module neutron_tof_four_momentum
  import ntfm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ntfm_in_if.sink    in_i,
  ntfm_out_if.source out_o
);

  logic      en;
  logic      front_v;
  front_t    front;
  lane_res_t lane_res [NUM_LANES];

  // distance and flight times
  ntfm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .in_i    (in_i),
    .valid_o (front_v),
    .front_o (front)
  );

  // one lane each for main hit and the two extras
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    ntfm_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (front.d),
      .tof_i (front.tof[g]),
      .res_o (lane_res[g])
    );
  end

  // gating and serialization of the three results
  ntfm_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_v),
    .dir_i   (front.dir),
    .res_i   (lane_res),
    .en_o    (en),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

### sim/ntfm_checker.sv
`default_nettype none
module ntfm_checker
  import ntfm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ntfm_in_if   in_c,
  ntfm_out_if  out_c,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   valid_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    which_t      which;
    logic        ok;
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
    logic [31:0] en;
    logic [31:0] ft;
    logic        last;
  } mom_res_t;

  mom_res_t awaited_moms[$];

  // integer square root, floor
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // four-momentum of one lane
  function automatic mom_res_t lane_mom(which_t w, bit allowed, longint unsigned d,
                                        longint tof, bit shown, longint dv[3]);
    mom_res_t        m;
    longint unsigned dd, len, r, bq, b2, q, s, p, e;
    m.which = w;
    m.ft    = shown ? clamp32(tof) : 32'd0;
    m.last  = (w == WHICH_TWO);
    m.ok    = 1'b0;
    m.mx    = '1;
    m.my    = '1;
    m.mz    = '1;
    m.en    = '1;
    if (allowed && d > 0 && tof > 0) begin
      dd  = d * 64'd100000000;
      len = longint'(tof) * 64'd299792458;
      if (dd < len) begin
        r  = dd;
        bq = 0;
        for (int i = 0; i < 32; i++) begin
          r  = r << 1;
          bq = bq << 1;
          if (r >= len) begin
            r  -= len;
            bq |= 1;
          end
        end
        b2 = (bq * bq) >> 32;
        q  = (64'd1 << 32) - b2;
        if (q > 64'hffff_ffff) q = 64'hffff_ffff;
        s = int_root(q << 32);
        if (s == 0) s = 1;
        p = (64'd939570 * bq) / s;
        e = (64'd939570 << 32) / s;
        m.mx = clamp32((longint'(p) * dv[0]) / 32768);
        m.my = clamp32((longint'(p) * dv[1]) / 32768);
        m.mz = clamp32((longint'(p) * dv[2]) / 32768);
        m.en = (e > 64'hffff_ffff) ? 32'hffff_ffff : e[31:0];
        m.ok = 1'b1;
      end
    end
    return m;
  endfunction

  // expected results of one accepted hit
  task automatic predict_hit();
    longint          x, y, z, tgt;
    longint          dv[3];
    longint unsigned d;
    mom_res_t        m;
    bit              main_ok;
    x     = longint'(in_c.offset_x);
    y     = longint'(in_c.offset_y);
    z     = longint'(in_c.offset_z);
    dv[0] = longint'(in_c.dir_x);
    dv[1] = longint'(in_c.dir_y);
    dv[2] = longint'(in_c.dir_z);
    tgt   = longint'(in_c.target_time);
    d     = int_root(x * x + y * y + z * z);
    m       = lane_mom(WHICH_MAIN, 1'b1, d, longint'(in_c.hit_time) - tgt, 1'b1, dv);
    main_ok = m.ok;
    awaited_moms.push_back(m);
    awaited_moms.push_back(lane_mom(WHICH_ONE, main_ok && in_c.has_extra_one, d,
        in_c.has_extra_one ? longint'(in_c.extra_time_one) - tgt : 0,
        in_c.has_extra_one, dv));
    awaited_moms.push_back(lane_mom(WHICH_TWO, main_ok && in_c.has_extra_two, d,
        in_c.has_extra_two ? longint'(in_c.extra_time_two) - tgt : 0,
        in_c.has_extra_two, dv));
  endtask

  task automatic field_chk(string nm, logic [31:0] ex, logic [31:0] ac);
    if (ex !== ac) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, nm, ex, ac);
      fail_count++;
    end
  endtask

  // compare each result request with the oldest expectation
  always @(posedge clk_i) begin
    mom_res_t m;
    if (rst_ni) begin
      if (in_c.valid && in_c.ready) predict_hit();
      if (out_c.valid && out_c.ready) begin
        results_seen++;
        if (awaited_moms.size() == 0) begin
          $display("%0t unexpected result, expected none actual which %0d", $time,
                   out_c.which);
          fail_count++;
        end else begin
          m = awaited_moms.pop_front();
          if (out_c.valid_res === 1'b1) valid_seen++;
          field_chk("which", 32'(m.which), 32'(out_c.which));
          field_chk("valid_res", 32'(m.ok), 32'(out_c.valid_res));
          field_chk("mom_x", m.mx, out_c.mom_x);
          field_chk("mom_y", m.my, out_c.mom_y);
          field_chk("mom_z", m.mz, out_c.mom_z);
          field_chk("energy", m.en, out_c.energy);
          field_chk("flight_time", m.ft, out_c.flight_time);
          field_chk("last", 32'(m.last), 32'(out_c.last));
        end
      end
      pending = awaited_moms.size();
    end
  end
endmodule
`default_nettype wire

### sim/tb_top.sv
`default_nettype none
module tb_top;
  import ntfm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, results_seen, valid_seen;
  int   cycles = 0;
  int   hits_sent = 0;
  int   stall_left = 0;
  bit   calm = 1'b0;

  ntfm_in_if  in_c();
  ntfm_out_if out_c();

  neutron_tof_four_momentum uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_c),
    .out_o (out_c)
  );

  ntfm_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_c        (in_c),
    .out_c       (out_c),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen),
    .valid_seen  (valid_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("neutron_tof_four_momentum verification failed");
      $finish;
    end
  end

  // result side stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_c.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_c.ready <= 1'b0;
    end else begin
      out_c.ready <= 1'b1;
    end
  end

  function automatic in_pay_t build_hit(int ox, int oy, int oz, int dx, int dy, int dz,
                                        int th, int t1, int t2, int tt, bit h1, bit h2);
    in_pay_t h;
    h.x       = ox[19:0];
    h.y       = oy[19:0];
    h.z       = oz[19:0];
    h.dir.x   = dx[15:0];
    h.dir.y   = dy[15:0];
    h.dir.z   = dz[15:0];
    h.hit     = th;
    h.one     = t1;
    h.two     = t2;
    h.tgt     = tt;
    h.has_one = h1;
    h.has_two = h2;
    return h;
  endfunction

  function automatic int rand_off(bit near);
    return near ? int'($urandom_range(0, 4000)) - 2000
                : int'($urandom_range(0, 1000000)) - 500000;
  endfunction

  // flight time spread around the light limit
  function automatic longint rand_tof(longint tmin);
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return tmin + 1 + $urandom_range(0, 2 * int'(tmin) + 10);
    if (k < 7) return tmin + $urandom_range(0, 3) - 1;
    if (k < 8) return tmin / 2 - $urandom_range(0, 5);
    if (k < 9) return longint'($urandom_range(0, 400000000));
    return -longint'($urandom_range(0, 1000));
  endfunction

  // mostly physical hits with random content
  function automatic in_pay_t plausible_hit();
    int     ox, oy, oz, tt;
    bit     near;
    real    path_len;
    longint tmin;
    near     = $urandom_range(0, 2) == 0;
    ox       = rand_off(near);
    oy       = rand_off(near);
    oz       = rand_off(near);
    path_len = $sqrt(real'(ox) * ox + real'(oy) * oy + real'(oz) * oz);
    tmin     = longint'(path_len * 100000000.0 / 299792458.0);
    tt       = int'($urandom_range(0, 2000000000)) - 1000000000;
    return build_hit(ox, oy, oz, $urandom, $urandom, $urandom,
                     tt + int'(rand_tof(tmin)), tt + int'(rand_tof(tmin)),
                     tt + int'(rand_tof(tmin)), tt,
                     $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
  endfunction

  function automatic in_pay_t noise_hit();
    return build_hit(rand_off(1'b0), rand_off(1'b0), rand_off(1'b0), $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // one hit request, held until taken
  task automatic send_hit(in_pay_t h);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_c.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_c.valid          <= 1'b1;
    in_c.offset_x       <= h.x;
    in_c.offset_y       <= h.y;
    in_c.offset_z       <= h.z;
    in_c.dir_x          <= h.dir.x;
    in_c.dir_y          <= h.dir.y;
    in_c.dir_z          <= h.dir.z;
    in_c.hit_time       <= h.hit;
    in_c.extra_time_one <= h.one;
    in_c.extra_time_two <= h.two;
    in_c.target_time    <= h.tgt;
    in_c.has_extra_one  <= h.has_one;
    in_c.has_extra_two  <= h.has_two;
    @(posedge clk_i);
    while (!in_c.ready) @(posedge clk_i);
    hits_sent++;
  endtask

  initial begin
    in_c.valid          <= 1'b0;
    in_c.offset_x       <= '0;
    in_c.offset_y       <= '0;
    in_c.offset_z       <= '0;
    in_c.dir_x          <= '0;
    in_c.dir_y          <= '0;
    in_c.dir_z          <= '0;
    in_c.hit_time       <= '0;
    in_c.extra_time_one <= '0;
    in_c.extra_time_two <= '0;
    in_c.target_time    <= '0;
    in_c.has_extra_one  <= 1'b0;
    in_c.has_extra_two  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    // ordinary hit with both extras
    send_hit(build_hit(10000, 0, 20000, 0, 0, 32767, 30000, 40000, 50000, 0, 1, 1));
    // zero distance
    send_hit(build_hit(0, 0, 0, 100, 200, 300, 5000, 6000, 7000, 0, 1, 1));
    // zero and negative flight times
    send_hit(build_hit(1000, 1000, 1000, 1, 2, 3, 777, 776, 700, 777, 1, 1));
    send_hit(build_hit(1000, -1000, 1000, 1, 2, 3, -10, 900, 900, 0, 1, 1));
    // faster than light
    send_hit(build_hit(500000, 500000, 500000, 32767, 32767, 32767, 10, 20, 30, 0, 1, 1));
    // offset and direction extremes, beta near one, saturation
    send_hit(build_hit(500000, 500000, 500000, 32767, -32768, 32767, 288900, 288899,
                       2000000, 0, 1, 1));
    send_hit(build_hit(-500000, -500000, -500000, -32768, -32768, -32768, 288801, 288802,
                       288803, 0, 1, 1));
    // flight time saturation both ways
    send_hit(build_hit(100, 0, 0, 32767, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                       32'sh80000000, 1, 1));
    send_hit(build_hit(100, 0, 0, 0, 32767, 0, 32'sh80000000, 32'sh7fffffff, 0,
                       32'sh7fffffff, 1, 1));
    // absent extras
    send_hit(build_hit(3000, 4000, 0, 0, 0, 32767, 100000, 99999, 99999, 0, 0, 0));
    send_hit(build_hit(3000, 4000, 0, 0, 0, 32767, 100000, 99999, 99999, 0, 1, 0));
    send_hit(build_hit(3000, 4000, 0, 0, 0, 32767, 100000, 99999, 99999, 0, 0, 1));
    // invalid main hit with valid looking extras
    send_hit(build_hit(3000, 4000, 0, 0, 0, 32767, -5, 100000, 100000, 0, 1, 1));
    // direction not unit length
    send_hit(build_hit(20000, 20000, 0, 32767, 32767, 32767, 50000, 60000, 70000, 100, 1, 1));
    send_hit(build_hit(20000, 20000, 0, 0, 0, 0, 50000, 60000, 70000, 100, 1, 1));

    // random part, with one full drain in the middle
    for (int i = 0; i < 395; i++) begin
      if (i == 200) begin
        in_c.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if (i == 330) calm = 1'b1;
      send_hit($urandom_range(0, 5) == 0 ? noise_hit() : plausible_hit());
    end
    in_c.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("sent %0d hits, checked %0d results of which %0d valid", hits_sent,
             results_seen, valid_seen);
    $display("covered zero distance, nonpositive and superluminal flight, saturation, absent extras");
    if (fail_count == 0 && pending == 0) begin
      $display("neutron_tof_four_momentum verification clean");
    end else begin
      $display("neutron_tof_four_momentum verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
